/* rtl/lrl_pkg.sv */
`timescale 1ns / 1ps
package lrl_pkg;

    localparam int KEY_W = 32;
    localparam int OCC_W = 6;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_TOUCH  = 2'd2;
    localparam logic [1:0] CMD_EVICT  = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_MISS  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] key_out;
        logic [OCC_W-1:0] occupancy;
    } t_result;

endpackage

/* rtl/lrl_match.sv */
`timescale 1ns / 1ps
module lrl_match #(
    parameter int KEY_BYTES = 4
) (
    input  logic [lrl_pkg::KEY_W-1:0] i_a,
    input  logic [lrl_pkg::KEY_W-1:0] i_b,
    output logic                      o_hit
);

    // only the low KEY_BYTES bytes take part, capped at the full key
    localparam int MB = (KEY_BYTES > 4) ? 4 : KEY_BYTES;
    localparam logic [lrl_pkg::KEY_W-1:0] MASK =
        lrl_pkg::KEY_W'((64'd1 << (8 * MB)) - 64'd1);

    assign o_hit = ((i_a ^ i_b) & MASK) == '0;

endmodule

/* rtl/lrl_core.sv */
`timescale 1ns / 1ps
module lrl_core #(
    parameter int DEPTH     = 32,
    parameter int KEY_BYTES = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [1:0]                i_command,
    input  logic [lrl_pkg::KEY_W-1:0] i_key,
    output logic                      o_busy,
    output logic                      o_res_valid,
    input  logic                      i_res_take,
    output lrl_pkg::t_result          o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEP_S    = SW'(DEPTH);
    localparam logic [AW-1:0] LAST     = AW'(DEPTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_MOVE  = 3'd2;
    localparam logic [2:0] S_FRONT = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    // logical position (0 = head) to slot in the circular store
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] idx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(idx);
        if (sum >= DEP_S) sum = sum - DEP_S;
        return sum[AW-1:0];
    endfunction

    logic [2:0]                r_state, n_state;
    logic [AW-1:0]             r_head, n_head;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx, n_idx;
    logic [1:0]                r_status, n_status;
    logic [1:0]                r_cmd;
    logic [lrl_pkg::KEY_W-1:0] r_key;
    logic [lrl_pkg::KEY_W-1:0] r_found;
    logic [lrl_pkg::KEY_W-1:0] r_rd_data;
    logic [lrl_pkg::KEY_W-1:0] r_mem [DEPTH];

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [lrl_pkg::KEY_W-1:0] wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             head_dec;
    logic                      hit;

    lrl_match #(
        .KEY_BYTES (KEY_BYTES)
    ) u_match (
        .i_a   (r_rd_data),
        .i_b   (r_key),
        .o_hit (hit)
    );

    assign head_dec = (r_head == '0) ? LAST : r_head - AW'(1);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_idx    = r_idx;
        n_status = r_status;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_status = lrl_pkg::STAT_OK;
                    n_idx    = '0;
                    n_state  = S_RESP;
                    case (i_command)
                        lrl_pkg::CMD_INSERT: begin
                            if (r_count == FULL_CNT) begin
                                n_status = lrl_pkg::STAT_FULL;
                            end else begin
                                n_head  = head_dec;
                                wr_en   = 1'b1;
                                wr_addr = head_dec;
                                wr_data = i_key;
                                n_count = r_count + CW'(1);
                            end
                        end
                        lrl_pkg::CMD_APPEND: begin
                            if (r_count == FULL_CNT) begin
                                n_status = lrl_pkg::STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = f_phys(r_head, r_count);
                                wr_data = i_key;
                                n_count = r_count + CW'(1);
                            end
                        end
                        lrl_pkg::CMD_TOUCH: begin
                            if (r_count == '0) begin
                                n_status = lrl_pkg::STAT_MISS;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                            // evict: tail key comes back through the read register
                            if (r_count == '0) begin
                                n_status = lrl_pkg::STAT_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                rd_en   = 1'b1;
                                rd_addr = f_phys(r_head, r_count - CW'(1));
                            end
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (hit) begin
                    if (r_idx == '0) begin
                        n_state = S_RESP;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = f_phys(r_head, r_idx - CW'(1));
                        n_state = S_MOVE;
                    end
                end else if (r_idx + CW'(1) == r_count) begin
                    n_status = lrl_pkg::STAT_MISS;
                    n_state  = S_RESP;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    rd_en   = 1'b1;
                    rd_addr = f_phys(r_head, r_idx + CW'(1));
                end
            end
            S_MOVE: begin
                // slot idx takes idx-1 while idx-2 is fetched
                wr_en   = 1'b1;
                wr_addr = f_phys(r_head, r_idx);
                wr_data = r_rd_data;
                if (r_idx == CW'(1)) begin
                    n_state = S_FRONT;
                end else begin
                    n_idx   = r_idx - CW'(1);
                    rd_en   = 1'b1;
                    rd_addr = f_phys(r_head, r_idx - CW'(2));
                end
            end
            S_FRONT: begin
                wr_en   = 1'b1;
                wr_addr = r_head;
                wr_data = r_found;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_res_take) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        if (r_state == S_IDLE && i_valid) begin
            r_cmd <= i_command;
            r_key <= i_key;
        end
        if (r_state == S_SRCH) r_found <= r_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_res_valid = r_state == S_RESP;

    always_comb begin
        o_result.status    = r_status;
        o_result.occupancy = lrl_pkg::OCC_W'(r_count);
        if (r_cmd == lrl_pkg::CMD_EVICT && r_status == lrl_pkg::STAT_OK) begin
            o_result.key_out = r_rd_data;
        end else begin
            o_result.key_out = '0;
        end
    end

endmodule

/* rtl/lru_recency_list_top.sv */
`timescale 1ns / 1ps
// One request at a time: the key store (one write and one read port) and one compare unit walk the list.
// A new request is taken while an earlier result still waits in the output register.
// Reset clears head pointer and entry count; stored keys are not cleared.
module lru_recency_list_top #(
    parameter int DEPTH     = 32,
    parameter int KEY_BYTES = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_command,
    input  logic [lrl_pkg::KEY_W-1:0] i_key,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_status,
    output logic [lrl_pkg::KEY_W-1:0] o_key_out,
    output logic [lrl_pkg::OCC_W-1:0] o_occupancy
);

    logic             busy;
    logic             res_valid;
    logic             res_take;
    lrl_pkg::t_result result;
    lrl_pkg::t_result r_out;
    logic             r_out_valid;

    lrl_core #(
        .DEPTH     (DEPTH),
        .KEY_BYTES (KEY_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .i_key       (i_key),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_result    (result)
    );

    assign res_take = res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) r_out <= result;
    end

    assign o_stall     = busy;
    assign o_valid     = r_out_valid;
    assign o_status    = r_out.status;
    assign o_key_out   = r_out.key_out;
    assign o_occupancy = r_out.occupancy;

`ifndef SYNTH
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == lrl_pkg::STAT_FULL) |->
            o_occupancy == lrl_pkg::OCC_W'(DEPTH))
        else $error("full status with occupancy below depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == lrl_pkg::STAT_EMPTY) |->
            (o_occupancy == '0 && o_key_out == '0))
        else $error("empty status with nonzero key or occupancy");

    a_key_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_out != '0) |-> o_status == lrl_pkg::STAT_OK)
        else $error("evicted key returned on failed request");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken without sequencer leaving idle");
`endif

endmodule
